// ===== src/rlps_pkg.sv =====
// ----------------------------------------------------------------------------
// rlps_pkg
// Types, codes and the colour table shared by the RGB LED pattern sequencer.
// ----------------------------------------------------------------------------
package rlps_pkg;

   // Item kinds.
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_SET  = 2'd1;
   localparam logic [1:0] KIND_OFF  = 2'd2;

   // Pattern codes.
   localparam logic [2:0] PAT_SOLID = 3'd0;
   localparam logic [2:0] PAT_SLOW  = 3'd1;
   localparam logic [2:0] PAT_FAST  = 3'd2;
   localparam logic [2:0] PAT_FLASH = 3'd3;
   localparam logic [2:0] PAT_PULSE = 3'd4;

   // Colour codes.
   localparam logic [2:0] COL_OFF    = 3'd0;
   localparam logic [2:0] COL_RED    = 3'd1;
   localparam logic [2:0] COL_GREEN  = 3'd2;
   localparam logic [2:0] COL_BLUE   = 3'd3;
   localparam logic [2:0] COL_WHITE  = 3'd4;
   localparam logic [2:0] COL_ORANGE = 3'd5;
   localparam logic [2:0] COL_CYAN   = 3'd6;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOW_HALF  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_HALF  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLASH_LEN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_HALF = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_CNT  = 3'd4;

   // Register reset values.
   localparam logic [15:0] SLOW_HALF_RESET  = 16'd1000;
   localparam logic [15:0] FAST_HALF_RESET  = 16'd200;
   localparam logic [15:0] FLASH_LEN_RESET  = 16'd200;
   localparam logic [15:0] PULSE_HALF_RESET = 16'd150;
   localparam logic [3:0]  PULSE_CNT_RESET  = 4'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] colour_code;
      logic [2:0] pattern_code;
   } req_type;

   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
      logic       onboard_on;
   } rsp_type;

   // Red, green, blue duty for a colour code, packed red in the top byte.
   function automatic logic [23:0] colour_levels(input logic [2:0] code);
      logic [23:0] levels;
      case (code)
         COL_RED:    levels = 24'hFF0000;
         COL_GREEN:  levels = 24'h00FF00;
         COL_BLUE:   levels = 24'h0000FF;
         COL_WHITE:  levels = 24'hFFFFFF;
         COL_ORANGE: levels = 24'hFF5000;
         COL_CYAN:   levels = 24'h00FFFF;
         default:    levels = 24'h000000;
      endcase
      return levels;
   endfunction

endpackage

// ===== src/rgb_led_pattern_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// rgb_led_pattern_sequencer_core
// Runs solid, blink, flash and pulse patterns for an RGB LED and an onboard
// LED, one command or millisecond tick per item.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result item, which carries the
// RGB duty levels and the onboard LED drive as they stand after that item.
// The pattern state is updated by a single compare-and-update step at the
// edge where the item is accepted, where the result is also registered
// into the output queue; one item can be accepted in every cycle while
// req_stall is low. The elapsed-time subtract and compare on the TIME_BITS wide
// millisecond clock sets the length of that path. A two-entry output queue
// (result register plus a skid register) lets the block take an item while
// one result still waits; req_stall rises only once both entries are full.
// Configuration registers may only be written while the block is idle.
module rgb_led_pattern_sequencer_core #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rlps_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rlps_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [rlps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rlps_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import rlps_pkg::*;

   // Configuration registers.
   logic [15:0] slow_half_ff;
   logic [15:0] fast_half_ff;
   logic [15:0] flash_len_ff;
   logic [15:0] pulse_half_ff;
   logic [3:0]  pulse_cnt_ff;

   // Pattern state. now_ff holds the millisecond clock plus one, which is the
   // value the clock takes on the next tick, so a tick needs no add in front
   // of the elapsed-time subtract.
   logic [TIME_BITS-1:0] now_ff,    now_in;
   logic [TIME_BITS-1:0] last_ff,   last_in;
   logic                 phase_ff,  phase_in;
   logic [3:0]           count_ff,  count_in;
   logic [2:0]           colour_ff, colour_in;
   logic [2:0]           pattern_ff, pattern_in;
   logic [23:0]          levels_ff, levels_in;
   logic                 onboard_ff, onboard_in;

   // Output queue.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;

   logic                 accept;
   logic                 pop;
   logic [TIME_BITS-1:0] elapsed;
   logic [15:0]          limit;
   logic                 over;
   rsp_type              result;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Elapsed time since the last toggle, measured against the clock value
   // this tick will set; wraps modulo 2^TIME_BITS like the clock itself.
   assign elapsed = now_ff - last_ff;

   always_comb begin
      case (pattern_ff)
         PAT_SLOW:  limit = slow_half_ff;
         PAT_FAST:  limit = fast_half_ff;
         PAT_FLASH: limit = flash_len_ff;
         default:   limit = pulse_half_ff;
      endcase
   end

   assign over = elapsed > TIME_BITS'(limit);

   // One step of the sequencer for the item at the input.
   always_comb begin
      now_in     = now_ff;
      last_in    = last_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      colour_in  = colour_ff;
      pattern_in = pattern_ff;
      levels_in  = levels_ff;
      onboard_in = onboard_ff;
      case (req_data.kind)
         KIND_TICK: begin
            now_in = now_ff + TIME_BITS'(1);
            case (pattern_ff)
               PAT_SLOW, PAT_FAST: begin
                  if (over) begin
                     phase_in  = !phase_ff;
                     last_in   = now_ff;
                     levels_in = !phase_ff ? colour_levels(colour_ff) : 24'h000000;
                  end
               end
               PAT_FLASH: begin
                  // The first tick lights the flash; a later tick past the
                  // flash length turns everything off.
                  if (count_ff == 4'd0) begin
                     count_in  = 4'd1;
                     last_in   = now_ff;
                     levels_in = colour_levels(colour_ff);
                  end else if (over) begin
                     colour_in  = COL_OFF;
                     pattern_in = PAT_SOLID;
                     levels_in  = 24'h000000;
                     onboard_in = 1'b0;
                  end
               end
               PAT_PULSE: begin
                  // The burst ends once the toggle budget is used up.
                  if (count_ff >= pulse_cnt_ff) begin
                     colour_in  = COL_OFF;
                     pattern_in = PAT_SOLID;
                     levels_in  = 24'h000000;
                     onboard_in = 1'b0;
                  end else if (over) begin
                     phase_in  = !phase_ff;
                     last_in   = now_ff;
                     levels_in = !phase_ff ? colour_levels(colour_ff) : 24'h000000;
                     count_in  = count_ff + 4'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         KIND_SET: begin
            colour_in  = req_data.colour_code;
            pattern_in = req_data.pattern_code;
            last_in    = '0;
            phase_in   = 1'b1;
            count_in   = 4'd0;
            if (req_data.pattern_code == PAT_SOLID) begin
               levels_in  = colour_levels(req_data.colour_code);
               onboard_in = req_data.colour_code != COL_OFF;
            end
         end
         KIND_OFF: begin
            colour_in  = COL_OFF;
            pattern_in = PAT_SOLID;
            levels_in  = 24'h000000;
            onboard_in = 1'b0;
         end
         default: begin
            // An unknown kind leaves the state alone and repeats the drive.
         end
      endcase
   end

   assign result.red_level   = levels_in[23:16];
   assign result.green_level = levels_in[15:8];
   assign result.blue_level  = levels_in[7:0];
   assign result.onboard_on  = onboard_in;

   // Output queue: the result register is refilled from the skid register
   // first, so items leave in the order they were accepted.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_half_ff  <= SLOW_HALF_RESET;
         fast_half_ff  <= FAST_HALF_RESET;
         flash_len_ff  <= FLASH_LEN_RESET;
         pulse_half_ff <= PULSE_HALF_RESET;
         pulse_cnt_ff  <= PULSE_CNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLOW_HALF:  slow_half_ff  <= csr_wdata;
            CSR_FAST_HALF:  fast_half_ff  <= csr_wdata;
            CSR_FLASH_LEN:  flash_len_ff  <= csr_wdata;
            CSR_PULSE_HALF: pulse_half_ff <= csr_wdata;
            CSR_PULSE_CNT:  pulse_cnt_ff  <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff     <= TIME_BITS'(1);
         last_ff    <= '0;
         phase_ff   <= 1'b0;
         count_ff   <= 4'd0;
         colour_ff  <= COL_OFF;
         pattern_ff <= PAT_SOLID;
         levels_ff  <= 24'h000000;
         onboard_ff <= 1'b0;
      end else if (accept) begin
         now_ff     <= now_in;
         last_ff    <= last_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         colour_ff  <= colour_in;
         pattern_ff <= pattern_in;
         levels_ff  <= levels_in;
         onboard_ff <= onboard_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB LED pattern sequencer core.
// ----------------------------------------------------------------------------
// A short directed list walks several solid colours, the off command, the ignored
// kind and each pattern. A random part then runs under several register
// settings, including the lowest and highest values. Every result item is
// checked field by field against an in-bench model of the LED state. The
// sender idles in bursts, and the receiver stalls in patterns of its own,
// with long hold-offs that fill the output queue.
// ----------------------------------------------------------------------------
module tb_top;
   import rlps_pkg::*;

   localparam int unsigned TB_TIME_BITS    = 32;
   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned PHASE_ITEMS     = 66;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned HOLD_OFF_CYCLES = 48;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned RUN_LIMIT_NS    = 5_000_000;

   // Codes outside the defined sets. The block must tolerate all of them.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] COL_UNKNOWN = 3'd7;
   localparam logic [2:0] PAT_UNKNOWN = 3'd5;
   localparam logic [2:0] PAT_TOP     = 3'd7;

   // Rows of the directed list. Where typed is set, want holds a result that
   // is obvious by inspection and is used in place of the model's answer.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } plan_row_type;

   // How the receiver stalls during one stretch of cycles.
   typedef enum int unsigned {
      FLOW_FREE,
      FLOW_COIN,
      FLOW_SPARSE,
      FLOW_HEAVY
   } flow_style_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   rsp_type      expected_leds [$];
   plan_row_type plan [$];
   int           error_count = 0;
   int           burst_left  = 0;

   // Model of the sequencer: register copies and pattern state.
   logic [15:0]             slow_ms, fast_ms, flash_ms, pulse_ms;
   logic [3:0]              pulse_limit;
   logic [TB_TIME_BITS-1:0] now_ms, toggled_at_ms;
   logic                    phase_lit;
   logic [3:0]              toggles_done;
   logic [2:0]              held_colour, held_pattern;
   logic [23:0]             rgb_drive;
   logic                    onboard_lit;

   always #5 clock = ~clock;

   rgb_led_pattern_sequencer_core #(
      .TIME_BITS(TB_TIME_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Red in the top byte, blue in the bottom one. Codes without a colour,
   // including the undefined one, are dark.
   function automatic logic [23:0] duty_for(input logic [2:0] code);
      case (code)
         COL_RED:    return 24'hFF0000;
         COL_GREEN:  return 24'h00FF00;
         COL_BLUE:   return 24'h0000FF;
         COL_WHITE:  return 24'hFFFFFF;
         COL_ORANGE: return 24'hFF5000;
         COL_CYAN:   return 24'h00FFFF;
         default:    return 24'h000000;
      endcase
   endfunction

   // Off forgets the stored colour and pattern and darkens both LEDs.
   function automatic void go_dark();
      held_colour  = COL_OFF;
      held_pattern = PAT_SOLID;
      rgb_drive    = '0;
      onboard_lit  = 1'b0;
   endfunction

   // One blink or pulse toggle. The onboard LED is left alone.
   function automatic void flip_phase();
      phase_lit     = ~phase_lit;
      toggled_at_ms = now_ms;
      rgb_drive     = phase_lit ? duty_for(held_colour) : 24'h000000;
   endfunction

   // Applies one item to the model and returns the drive it leaves behind.
   function automatic rsp_type predict_leds(input req_type item);
      logic [TB_TIME_BITS-1:0] elapsed;
      rsp_type                 result;
      case (item.kind)
         KIND_TICK: begin
            now_ms  = now_ms + 1'b1;
            // Elapsed time wraps with the clock, so a plain subtract works.
            elapsed = now_ms - toggled_at_ms;
            case (held_pattern)
               PAT_SLOW: if (elapsed > slow_ms) flip_phase();
               PAT_FAST: if (elapsed > fast_ms) flip_phase();
               PAT_FLASH: begin
                  // The first tick lights the flash and starts its timer.
                  if (toggles_done == 4'd0) begin
                     toggles_done  = 4'd1;
                     toggled_at_ms = now_ms;
                     rgb_drive     = duty_for(held_colour);
                  end else if (elapsed > flash_ms) begin
                     go_dark();
                  end
               end
               PAT_PULSE: begin
                  // The burst ends before any timing test once it is full;
                  // with a limit of zero that is the very first tick.
                  if (toggles_done >= pulse_limit) begin
                     go_dark();
                  end else if (elapsed > pulse_ms) begin
                     flip_phase();
                     toggles_done = toggles_done + 4'd1;
                  end
               end
               default: ;
            endcase
         end
         KIND_SET: begin
            // A set restarts the pattern timer from zero, not from now.
            held_colour   = item.colour_code;
            held_pattern  = item.pattern_code;
            toggled_at_ms = '0;
            phase_lit     = 1'b1;
            toggles_done  = 4'd0;
            if (item.pattern_code == PAT_SOLID) begin
               rgb_drive   = duty_for(item.colour_code);
               onboard_lit = (item.colour_code != COL_OFF);
            end
         end
         KIND_OFF: go_dark();
         default: ;
      endcase
      result.red_level   = rgb_drive[23:16];
      result.green_level = rgb_drive[15:8];
      result.blue_level  = rgb_drive[7:0];
      result.onboard_on  = onboard_lit;
      return result;
   endfunction

   function automatic plan_row_type model_row(input logic [1:0] kind,
                                              input logic [2:0] colour,
                                              input logic [2:0] pattern);
      plan_row_type r;
      r.item  = '{kind: kind, colour_code: colour, pattern_code: pattern};
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [1:0] kind,
                                              input logic [2:0] colour,
                                              input logic [2:0] pattern,
                                              input rsp_type    want);
      plan_row_type r;
      r       = model_row(kind, colour, pattern);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   // Mostly ticks, so that the patterns get to run between commands. Colour
   // and pattern bits are random on every kind, undefined codes included.
   function automatic req_type random_item();
      req_type     item;
      int unsigned roll;
      roll              = $urandom_range(0, 99);
      item.colour_code  = 3'($urandom_range(0, 7));
      item.pattern_code = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                       : 3'($urandom_range(0, 7));
      if (roll < 70)      item.kind = KIND_TICK;
      else if (roll < 90) item.kind = KIND_SET;
      else if (roll < 95) item.kind = KIND_OFF;
      else                item.kind = KIND_UNUSED;
      return item;
   endfunction

   // Register writes only happen while the block is idle, so the model copy
   // can change at once.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (index)
         CSR_SLOW_HALF:  slow_ms     = value;
         CSR_FAST_HALF:  fast_ms     = value;
         CSR_FLASH_LEN:  flash_ms    = value;
         CSR_PULSE_HALF: pulse_ms    = value;
         CSR_PULSE_CNT:  pulse_limit = value[3:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] slow, input logic [15:0] fast,
                                 input logic [15:0] flash, input logic [15:0] pulse,
                                 input logic [3:0] toggles);
      write_reg(CSR_SLOW_HALF, slow);
      write_reg(CSR_FAST_HALF, fast);
      write_reg(CSR_FLASH_LEN, flash);
      write_reg(CSR_PULSE_HALF, pulse);
      write_reg(CSR_PULSE_CNT, {12'd0, toggles});
   endtask

   // Offers one item and holds it until the block takes it. Called and left
   // at a falling edge. Valid stays high across a burst; it only drops for a
   // gap between bursts, so it is never lowered and raised in one step.
   task automatic offer_item(input plan_row_type row);
      int unsigned gap;
      rsp_type     predicted;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= row.item;
      // req_stall is read just after the edge, so this is its value at it.
      do @(posedge clock); while (req_stall);
      predicted = predict_leds(row.item);
      expected_leds.push_back(row.typed ? row.want : predicted);
      @(negedge clock);
   endtask

   // Stops offering and waits for every expected result. Each item yields
   // exactly one result, so nothing can still be in flight after that.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_leds.size() != 0) @(negedge clock);
   endtask

   // Result checker. Each result taken is matched against the oldest
   // expectation; anything arriving with nothing expected is an error too.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_leds.size() == 0) begin
            $display("%0t: result with nothing expected: r=%02h g=%02h b=%02h on=%0b",
                     $time, rsp_data.red_level, rsp_data.green_level,
                     rsp_data.blue_level, rsp_data.onboard_on);
            error_count++;
         end else begin
            want = expected_leds.pop_front();
            if (rsp_data.red_level !== want.red_level ||
                rsp_data.green_level !== want.green_level ||
                rsp_data.blue_level !== want.blue_level ||
                rsp_data.onboard_on !== want.onboard_on) begin
               $display({"%0t: mismatch: expected r=%02h g=%02h b=%02h on=%0b,",
                         " got r=%02h g=%02h b=%02h on=%0b"},
                        $time, want.red_level, want.green_level, want.blue_level,
                        want.onboard_on, rsp_data.red_level, rsp_data.green_level,
                        rsp_data.blue_level, rsp_data.onboard_on);
               error_count++;
            end
         end
      end
   end

   // Receiver. It stalls in stretches of random length, each with its own
   // style: never, half the time, now and then, or most of the time. Every
   // twenty stretches it also owes a long hold-off, which it takes as soon as
   // the sender is offering, so that both output entries fill up and the
   // block has to push back on its input.
   initial begin : receiver
      int unsigned    seg_count;
      int unsigned    span;
      logic           hold_due;
      flow_style_type style;
      seg_count = 0;
      hold_due  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         seg_count++;
         if (seg_count % 20 == 2) hold_due = 1'b1;
         if (hold_due && req_valid) begin
            hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            style = flow_style_type'($urandom_range(0, 3));
            span  = $urandom_range(4, 40);
            repeat (span) begin
               case (style)
                  FLOW_FREE:   rsp_stall <= 1'b0;
                  FLOW_COIN:   rsp_stall <= ($urandom_range(0, 1) == 1);
                  FLOW_SPARSE: rsp_stall <= ($urandom_range(0, 7) == 0);
                  default:     rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // Stimulus. The directed list first runs under the reset settings, where
   // solid colours, off and the ignored kind give results one can read at a
   // glance. Then short periods are written, so that every pattern visibly
   // toggles, flashes or ends within a handful of ticks. Random phases
   // follow, each under its own register settings: all lowest, all highest,
   // a fixed small set, and random small ones.
   initial begin : stimulus
      localparam int unsigned KNOWN_ROWS = 7;
      int unsigned  counted;
      plan_row_type row;

      // Straight after reset a tick changes nothing, and neither does the
      // ignored kind; the undefined colour is dark but still lights onboard.
      plan.push_back(known_row(KIND_TICK, COL_WHITE, PAT_PULSE, {8'h00, 8'h00, 8'h00, 1'b0}));
      plan.push_back(known_row(KIND_UNUSED, COL_RED, PAT_SOLID, {8'h00, 8'h00, 8'h00, 1'b0}));
      plan.push_back(known_row(KIND_SET, COL_RED, PAT_SOLID, {8'hFF, 8'h00, 8'h00, 1'b1}));
      plan.push_back(known_row(KIND_SET, COL_ORANGE, PAT_SOLID, {8'hFF, 8'h50, 8'h00, 1'b1}));
      plan.push_back(known_row(KIND_SET, COL_UNKNOWN, PAT_SOLID, {8'h00, 8'h00, 8'h00, 1'b1}));
      plan.push_back(known_row(KIND_SET, COL_WHITE, PAT_SOLID, {8'hFF, 8'hFF, 8'hFF, 1'b1}));
      plan.push_back(known_row(KIND_OFF, COL_CYAN, PAT_TOP, {8'h00, 8'h00, 8'h00, 1'b0}));
      // Short periods from here on. Onboard is lit first, so the rows that
      // follow show that blink, flash and pulse steps leave it alone until
      // a pattern ends in off.
      plan.push_back(model_row(KIND_SET, COL_RED, PAT_SOLID));
      plan.push_back(model_row(KIND_SET, COL_GREEN, PAT_SLOW));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_SET, COL_CYAN, PAT_FAST));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_SET, COL_BLUE, PAT_FLASH));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_SET, COL_WHITE, PAT_PULSE));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));
      // An undefined pattern is stored, but neither the set nor a tick
      // drives anything.
      plan.push_back(model_row(KIND_SET, COL_ORANGE, PAT_UNKNOWN));
      plan.push_back(model_row(KIND_TICK, COL_OFF, PAT_SOLID));

      // Model state after reset, including the register reset values.
      slow_ms       = SLOW_HALF_RESET;
      fast_ms       = FAST_HALF_RESET;
      flash_ms      = FLASH_LEN_RESET;
      pulse_ms      = PULSE_HALF_RESET;
      pulse_limit   = PULSE_CNT_RESET;
      now_ms        = '0;
      toggled_at_ms = '0;
      phase_lit     = 1'b0;
      toggles_done  = 4'd0;
      held_colour   = COL_OFF;
      held_pattern  = PAT_SOLID;
      rgb_drive     = '0;
      onboard_lit   = 1'b0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < plan.size(); i++) begin
         if (i == KNOWN_ROWS) begin
            wait_idle();
            apply_settings(16'd2, 16'd0, 16'd1, 16'd0, 4'd2);
         end
         offer_item(plan[i]);
      end

      for (int phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         wait_idle();
         case (phase_idx)
            0:       apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
            1:       apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
            2:       apply_settings(16'd3, 16'd1, 16'd4, 16'd2, 4'd3);
            default: apply_settings(16'($urandom_range(0, 9)), 16'($urandom_range(0, 9)),
                                    16'($urandom_range(0, 9)), 16'($urandom_range(0, 9)),
                                    4'($urandom_range(0, 15)));
         endcase
         // Items of the ignored kind are sent but do not count here.
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            row.item  = random_item();
            row.typed = 1'b0;
            row.want  = '0;
            offer_item(row);
            if (row.item.kind != KIND_UNUSED) counted++;
         end
      end

      // Let the last results drain, then watch a few more cycles for
      // anything the block should not have sent.
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("%0t: run limit reached", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
